// ===== rtl/cbq_pkg.sv =====
// Shared types, constants and helpers for the cascaded biquad filter.
package cbq_pkg;

  localparam int SECTIONS     = 5;
  localparam int SEC_W        = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int COEF_COUNT   = 32;
  localparam int COEF_IDX_W   = $clog2(COEF_COUNT);
  localparam int COEF_PER_SEC = 6;
  localparam int COEF_W       = 16;
  localparam int CFG_REGS     = 8;
  localparam int CFG_IDX_W    = $clog2(CFG_REGS);
  localparam int CFG_W        = 64;
  localparam int COEF_PER_REG = CFG_W / COEF_W;
  localparam int GAIN_IDX     = 30;
  localparam int HIST_W       = 16;
  localparam int ACC_W        = 32;
  localparam int FRAC_BITS    = 14;
  localparam int SAMPLE_W     = 14;
  localparam int OUT_W        = 15;
  localparam int DAC_W        = 12;

  // Position of each coefficient within a section's group.
  localparam int C_B0    = 0;
  localparam int C_B1    = 1;
  localparam int C_B2    = 2;
  localparam int C_A1    = 3;
  localparam int C_A2    = 4;
  localparam int C_SCALE = 5;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 32'sd16383;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -32'sd16384;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_A1,
    ST_A2,
    ST_B0,
    ST_B1,
    ST_B2,
    ST_SCALE,
    ST_GAIN,
    ST_DONE
  } state_t;

  // Clamp a value to the 15-bit signed range.
  function automatic logic signed [OUT_W-1:0] sat15(input logic signed [ACC_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[OUT_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/cbq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module cbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/cascaded_biquad_q14_filter.sv =====
// Top level of the five-section cascaded biquad filter in Q14 fixed point.
//
// One 14-bit ADC sample enters on the in_ channel as a transfer when in_valid
// is high and in_stall is low. It runs through five direct-form-II biquad
// sections and an output gain, and one result (filtered, dac_code) leaves on
// the out_ channel. The history words of all sections live in one small
// synchronous RAM; a single 16x16 multiplier is shared by every product.
// Each section runs through the steps A1, A2, B0, B1, B2 and SCALE (five
// taps and the scale, one per product), then GAIN applies the output gain;
// the next sample is taken only once the last result is in the output
// register. in_stall is high while an item is in progress.
// The result sits in an output register; a stalled receiver holds it there
// while the next sample is taken and filtered. A finished result waits in
// the last step until the output register is free.
// Coefficients are written through cfg_we/cfg_index/cfg_wdata, four Q14 values
// per 64-bit word, only while the block is idle: a user rule, not enforced.
// Synchronous reset clears all coefficients and marks every history word as
// zero; no clearing pass is needed.
module cascaded_biquad_q14_filter (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [cbq_pkg::SAMPLE_W-1:0]           in_sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [cbq_pkg::OUT_W-1:0]       out_filtered,
  output logic [cbq_pkg::DAC_W-1:0]              out_dac_code,
  input  logic                                   cfg_we,
  input  logic [cbq_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [cbq_pkg::CFG_W-1:0]              cfg_wdata
);

  localparam int HW2 = 2 * cbq_pkg::HIST_W;

  cbq_pkg::state_t state_r, state_nxt;

  logic signed [cbq_pkg::COEF_W-1:0] coef_r [cbq_pkg::COEF_COUNT];

  logic signed [cbq_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [cbq_pkg::HIST_W-1:0] w1_r, w1_nxt;
  logic signed [cbq_pkg::HIST_W-1:0] w2_r, w2_nxt;
  logic signed [cbq_pkg::HIST_W-1:0] new_r, new_nxt;
  logic [cbq_pkg::SEC_W-1:0]         sec_r, sec_nxt;
  logic [cbq_pkg::SECTIONS-1:0]      hist_vld_r;

  logic                              out_valid_r;
  logic signed [cbq_pkg::OUT_W-1:0]  out_filtered_r;
  logic [cbq_pkg::DAC_W-1:0]         out_dac_r;

  logic                              in_xfer;
  logic                              last_sec;
  logic                              out_load;
  logic [2:0]                        coef_sel;
  logic [cbq_pkg::COEF_IDX_W-1:0]    coef_idx;
  logic signed [cbq_pkg::COEF_W-1:0] mul_a;
  logic signed [cbq_pkg::HIST_W-1:0] mul_b;
  logic signed [cbq_pkg::ACC_W-1:0]  prod;
  logic signed [cbq_pkg::OUT_W-1:0]  acc_sat;
  logic signed [cbq_pkg::OUT_W-1:0]  fin;

  logic                              ram_we;
  logic [cbq_pkg::SEC_W-1:0]         ram_raddr;
  logic [HW2-1:0]                    ram_wdata;
  logic [HW2-1:0]                    ram_rdata;
  logic signed [cbq_pkg::HIST_W-1:0] rd_w1;
  logic signed [cbq_pkg::HIST_W-1:0] rd_w2;

  // History words: history_one in the upper half, history_two in the lower.
  cbq_ram #(
    .WIDTH (HW2),
    .DEPTH (cbq_pkg::SECTIONS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sec_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_xfer  = in_valid && !in_stall;
  assign last_sec = (sec_r == cbq_pkg::SEC_W'(cbq_pkg::SECTIONS - 1));
  assign acc_sat  = cbq_pkg::sat15(acc_r >>> cbq_pkg::FRAC_BITS);
  assign prod     = mul_a * mul_b;

  // An entry never written since reset reads as zero.
  assign rd_w1 = hist_vld_r[sec_r] ? ram_rdata[HW2-1:cbq_pkg::HIST_W]   : '0;
  assign rd_w2 = hist_vld_r[sec_r] ? ram_rdata[cbq_pkg::HIST_W-1:0]     : '0;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cbq_pkg::ST_IDLE:  if (in_xfer) state_nxt = cbq_pkg::ST_LOAD;
      cbq_pkg::ST_LOAD:  state_nxt = cbq_pkg::ST_A1;
      cbq_pkg::ST_A1:    state_nxt = cbq_pkg::ST_A2;
      cbq_pkg::ST_A2:    state_nxt = cbq_pkg::ST_B0;
      cbq_pkg::ST_B0:    state_nxt = cbq_pkg::ST_B1;
      cbq_pkg::ST_B1:    state_nxt = cbq_pkg::ST_B2;
      cbq_pkg::ST_B2:    state_nxt = cbq_pkg::ST_SCALE;
      cbq_pkg::ST_SCALE: state_nxt = last_sec ? cbq_pkg::ST_GAIN : cbq_pkg::ST_A1;
      cbq_pkg::ST_GAIN:  state_nxt = cbq_pkg::ST_DONE;
      cbq_pkg::ST_DONE:  if (out_load) state_nxt = cbq_pkg::ST_IDLE;
      default:           state_nxt = cbq_pkg::ST_IDLE;
    endcase
  end

  // Multiplier operands, memory control and handshake outputs.
  always_comb begin
    in_stall  = (state_r != cbq_pkg::ST_IDLE);
    out_load  = (state_r == cbq_pkg::ST_DONE) && (!out_valid_r || !out_stall);
    ram_we    = (state_r == cbq_pkg::ST_SCALE);
    ram_wdata = {new_r, w1_r};
    ram_raddr = (state_r == cbq_pkg::ST_SCALE) ? sec_nxt : sec_r;
    coef_sel  = 3'(cbq_pkg::C_B0);
    mul_b     = '0;
    case (state_r)
      cbq_pkg::ST_A1: begin
        coef_sel = 3'(cbq_pkg::C_A1);
        mul_b    = rd_w1;
      end
      cbq_pkg::ST_A2: begin
        coef_sel = 3'(cbq_pkg::C_A2);
        mul_b    = w2_r;
      end
      cbq_pkg::ST_B0: begin
        coef_sel = 3'(cbq_pkg::C_B0);
        mul_b    = acc_r[cbq_pkg::FRAC_BITS +: cbq_pkg::HIST_W];
      end
      cbq_pkg::ST_B1: begin
        coef_sel = 3'(cbq_pkg::C_B1);
        mul_b    = w1_r;
      end
      cbq_pkg::ST_B2: begin
        coef_sel = 3'(cbq_pkg::C_B2);
        mul_b    = w2_r;
      end
      cbq_pkg::ST_SCALE: begin
        coef_sel = 3'(cbq_pkg::C_SCALE);
        mul_b    = cbq_pkg::HIST_W'(acc_sat);
      end
      cbq_pkg::ST_GAIN: begin
        mul_b    = cbq_pkg::HIST_W'(acc_sat);
      end
      default: begin
        mul_b    = '0;
      end
    endcase
    coef_idx = cbq_pkg::COEF_IDX_W'(32'(sec_r) * cbq_pkg::COEF_PER_SEC + 32'(coef_sel));
    if (state_r == cbq_pkg::ST_GAIN) begin
      mul_a = coef_r[cbq_pkg::GAIN_IDX];
    end else begin
      mul_a = coef_r[coef_idx];
    end
  end

  // Datapath next values.
  always_comb begin
    acc_nxt = acc_r;
    w1_nxt  = w1_r;
    w2_nxt  = w2_r;
    new_nxt = new_r;
    sec_nxt = sec_r;
    case (state_r)
      cbq_pkg::ST_IDLE: begin
        if (in_xfer) begin
          acc_nxt = $signed({4'b0000, in_sample, {cbq_pkg::FRAC_BITS{1'b0}}});
          sec_nxt = '0;
        end
      end
      cbq_pkg::ST_A1: begin
        acc_nxt = acc_r - prod;
        w1_nxt  = rd_w1;
        w2_nxt  = rd_w2;
      end
      cbq_pkg::ST_A2: acc_nxt = acc_r - prod;
      cbq_pkg::ST_B0: begin
        acc_nxt = prod;
        new_nxt = acc_r[cbq_pkg::FRAC_BITS +: cbq_pkg::HIST_W];
      end
      cbq_pkg::ST_B1: acc_nxt = acc_r + prod;
      cbq_pkg::ST_B2: acc_nxt = acc_r + prod;
      cbq_pkg::ST_SCALE: begin
        acc_nxt = prod;
        sec_nxt = last_sec ? '0 : sec_r + 1'b1;
      end
      cbq_pkg::ST_GAIN: acc_nxt = prod;
      default: acc_nxt = acc_r;
    endcase
  end

  assign fin = acc_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbq_pkg::ST_IDLE;
      sec_r       <= '0;
      hist_vld_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < cbq_pkg::COEF_COUNT; i++) begin
        coef_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      sec_r   <= sec_nxt;
      if (ram_we) begin
        hist_vld_r[sec_r] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        for (int k = 0; k < cbq_pkg::COEF_PER_REG; k++) begin
          coef_r[{cfg_index, 2'(k)}] <= cfg_wdata[k * cbq_pkg::COEF_W +: cbq_pkg::COEF_W];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    w1_r  <= w1_nxt;
    w2_r  <= w2_nxt;
    new_r <= new_nxt;
    if (out_load) begin
      out_filtered_r <= fin;
      // Negative results map to the bottom of the DAC range.
      out_dac_r      <= fin[cbq_pkg::OUT_W-1] ? '0 : fin[cbq_pkg::OUT_W-2:2];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;
  assign out_dac_code = out_dac_r;

endmodule
